[hdl/slesq_pkg.sv]
// ----------------------------------------------------------------------------
// slesq_pkg
// Shared types, constants and helper functions of the status LED effect
// sequencer.
// ----------------------------------------------------------------------------
package slesq_pkg;

  localparam int LED_COUNT    = 8;
  localparam int CHASE_LENGTH = 24;

  localparam int COLOR_W     = 24;
  localparam int STATE_W     = 4;
  localparam int IDX_W       = 3;
  localparam int CNT_W       = $clog2(LED_COUNT + 1);
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 32;
  localparam int OUT_PAD_W   = OUT_TDATA_W - IDX_W - COLOR_W;
  localparam int CFG_ADDR_W  = 3;
  localparam int LEVEL_W     = 5;
  localparam int PLUG_CNT_W  = 5;
  localparam int FLT_DIV_W   = 4;

  localparam logic [COLOR_W-1:0]     PLUG_COLOR   = 24'h000050;
  localparam logic [COLOR_W-1:0]     FAULT_COLOR  = 24'h9F0000;
  localparam logic [COLOR_W-1:0]     CHASE_TOP    = 24'h0000AF;
  localparam int                     CHASE_RAMP   = 18;
  localparam logic [PLUG_CNT_W-1:0]  PLUG_DIV     = 5'd25;
  localparam logic [FLT_DIV_W-1:0]   FAULT_DIV    = 4'd15;
  localparam logic [LEVEL_W-1:0]     BREATH_HIGH  = 5'd30;
  localparam logic [LEVEL_W-1:0]     BREATH_LOW   = 5'd5;
  localparam logic [LEVEL_W-1:0]     BREATH_RESET = 5'd10;
  localparam logic [7:0]             FIXED_BRIGHT = 8'd100;
  localparam logic [7:0]             BREATH_BASE  = 8'd10;

  localparam logic [COLOR_W-1:0] IDLE_COLOR_RST     = 24'h000080;
  localparam logic [COLOR_W-1:0] DONE_COLOR_RST     = 24'h008000;
  localparam logic [COLOR_W-1:0] SIM_COLOR_RST      = 24'hFFC0CB;
  localparam logic [COLOR_W-1:0] FALLBACK_COLOR_RST = 24'h800000;

  localparam logic [CNT_W-1:0] FRAME_LEN = CNT_W'(LED_COUNT);
  localparam logic [CNT_W-1:0] LAST_BEAT = CNT_W'(LED_COUNT - 1);

  typedef enum logic [STATE_W-1:0] {
    ST_REBOOT   = 4'd0,
    ST_IDLE     = 4'd1,
    ST_PLUGGED  = 4'd2,
    ST_CHARGING = 4'd3,
    ST_DONE     = 4'd4,
    ST_STOP     = 4'd5,
    ST_FAULT    = 4'd6,
    ST_SIM      = 4'd7
  } charger_state_e;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_IDLE_COLOR     = 3'd0,
    REG_DONE_COLOR     = 3'd1,
    REG_SIM_COLOR      = 3'd2,
    REG_FALLBACK_COLOR = 3'd3,
    REG_CHANNEL_ORDER  = 3'd4
  } cfg_reg_e;

  typedef enum logic [1:0] {
    ORD_RGB = 2'd0,
    ORD_BGR = 2'd1,
    ORD_GRB = 2'd2,
    ORD_RBG = 2'd3
  } channel_order_e;

  typedef struct packed {
    logic [COLOR_W-1:0] idle_color;
    logic [COLOR_W-1:0] done_color;
    logic [COLOR_W-1:0] sim_color;
    logic [COLOR_W-1:0] fallback_color;
    channel_order_e     channel_order;
  } cfg_t;

  typedef logic [LED_COUNT-1:0][COLOR_W-1:0] frame_t;

  typedef struct packed {
    logic   emit;
    frame_t colors;
  } frame_req_t;

  // reset content of the chase ring: descending blue ramp, then black
  function automatic logic [COLOR_W-1:0] chase_init(input int idx);
    logic [COLOR_W-1:0] val;
    val = '0;
    if (idx < CHASE_RAMP) begin
      val = CHASE_TOP - COLOR_W'(10 * idx);
    end
    return val;
  endfunction

  // floor(x / 255) via reciprocal estimate and one correction step
  function automatic logic [7:0] div255(input logic [15:0] x);
    logic [16:0] sum;
    logic [8:0]  q;
    logic [16:0] prod;
    logic [16:0] rem;
    sum  = {1'b0, x} + {9'b0, x[15:8]};
    q    = sum[16:8];
    prod = {q, 8'b0} - {8'b0, q};
    rem  = {1'b0, x} - prod;
    if (rem >= 17'd255) begin
      q = q + 9'd1;
    end
    return q[7:0];
  endfunction

  function automatic logic [COLOR_W-1:0] scale_color(input logic [COLOR_W-1:0] color,
                                                     input logic [7:0] bright,
                                                     input channel_order_e order);
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    logic [COLOR_W-1:0] res;
    r = div255(16'(color[23:16]) * 16'(bright));
    g = div255(16'(color[15:8]) * 16'(bright));
    b = div255(16'(color[7:0]) * 16'(bright));
    case (order)
      ORD_BGR: res = {b, g, r};
      ORD_GRB: res = {g, r, b};
      ORD_RBG: res = {r, b, g};
      default: res = {r, g, b};
    endcase
    return res;
  endfunction

endpackage

[hdl/slesq_cfg_regs.sv]
// ----------------------------------------------------------------------------
// slesq_cfg_regs
// Configuration register file: colors and output channel order.
// ----------------------------------------------------------------------------
module slesq_cfg_regs
  import slesq_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  input  logic [CFG_ADDR_W-1:0] cfg_addr_i,
  input  logic [COLOR_W-1:0]    cfg_data_i,
  output logic                  cfg_ready_o,
  output cfg_t                  cfg_o
);

  cfg_t cfg_q;
  cfg_t cfg_d;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_addr_i))
        REG_IDLE_COLOR:     cfg_d.idle_color     = cfg_data_i;
        REG_DONE_COLOR:     cfg_d.done_color     = cfg_data_i;
        REG_SIM_COLOR:      cfg_d.sim_color      = cfg_data_i;
        REG_FALLBACK_COLOR: cfg_d.fallback_color = cfg_data_i;
        REG_CHANNEL_ORDER:  cfg_d.channel_order  = channel_order_e'(cfg_data_i[1:0]);
        default:            cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.idle_color     <= IDLE_COLOR_RST;
      cfg_q.done_color     <= DONE_COLOR_RST;
      cfg_q.sim_color      <= SIM_COLOR_RST;
      cfg_q.fallback_color <= FALLBACK_COLOR_RST;
      cfg_q.channel_order  <= ORD_RGB;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

[hdl/slesq_effect_core.sv]
// ----------------------------------------------------------------------------
// slesq_effect_core
// Effect state (breathing, blink dividers, chase ring) and frame generation
// for one tick.
// ----------------------------------------------------------------------------
module slesq_effect_core
  import slesq_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               fire_i,
  input  logic [STATE_W-1:0] state_i,
  input  cfg_t               cfg_i,
  output frame_req_t         req_o
);

  logic [LEVEL_W-1:0]     level_q, level_d, level_step;
  logic                   phase_q, phase_d, phase_step;
  logic [PLUG_CNT_W-1:0]  plug_cnt_q, plug_cnt_d, plug_inc;
  logic [FLT_DIV_W-1:0]   flt_div_q, flt_div_d, fault_inc;
  logic [COLOR_W-1:0]     ring_q [CHASE_LENGTH];
  frame_t                 chase_frame;
  logic [COLOR_W-1:0]     fill_color;
  logic [7:0]             breath_bright;
  logic                   is_chase;
  logic                   plug_hit;
  logic                   fault_hit;

  // one breathing step from the current level
  always_comb begin
    if (!phase_q) begin
      level_step = level_q + LEVEL_W'(1);
      phase_step = (level_step == BREATH_HIGH);
    end else begin
      level_step = level_q - LEVEL_W'(1);
      phase_step = !(level_step == BREATH_LOW);
    end
  end

  assign breath_bright = BREATH_BASE + {1'b0, level_step, 2'b0} + {3'b0, level_step};
  assign plug_inc      = plug_cnt_q + PLUG_CNT_W'(1);
  assign fault_inc     = flt_div_q + FLT_DIV_W'(1);
  assign plug_hit      = (plug_inc >= PLUG_DIV);
  assign fault_hit     = (fault_inc >= FAULT_DIV);

  // led i shows ring entry i+1, the entry that the rotation brings to place i
  for (genvar i = 0; i < LED_COUNT; i++) begin : g_chase
    if (i < CHASE_LENGTH) begin : g_on
      assign chase_frame[i] = ring_q[(i + 1) % CHASE_LENGTH];
    end else begin : g_off
      assign chase_frame[i] = '0;
    end
  end

  always_comb begin
    level_d     = level_q;
    phase_d     = phase_q;
    plug_cnt_d  = plug_cnt_q;
    flt_div_d   = flt_div_q;
    fill_color  = '0;
    is_chase    = 1'b0;
    req_o.emit  = 1'b1;
    case (charger_state_e'(state_i))
      ST_REBOOT: begin
        fill_color = scale_color(cfg_i.idle_color, FIXED_BRIGHT, cfg_i.channel_order);
      end
      ST_IDLE: begin
        level_d    = level_step;
        phase_d    = phase_step;
        fill_color = scale_color(cfg_i.idle_color, breath_bright, cfg_i.channel_order);
      end
      ST_PLUGGED: begin
        req_o.emit = plug_hit;
        if (plug_hit) begin
          plug_cnt_d = '0;
          phase_d    = !phase_q;
          fill_color = phase_q ? PLUG_COLOR : '0;
        end else begin
          plug_cnt_d = plug_inc;
        end
      end
      ST_CHARGING: begin
        is_chase = 1'b1;
      end
      ST_DONE: begin
        fill_color = scale_color(cfg_i.done_color, FIXED_BRIGHT, cfg_i.channel_order);
      end
      ST_STOP: begin
        level_d    = level_step;
        phase_d    = phase_step;
        fill_color = scale_color(cfg_i.done_color, breath_bright, cfg_i.channel_order);
      end
      ST_FAULT: begin
        req_o.emit = fault_hit;
        if (fault_hit) begin
          flt_div_d  = '0;
          phase_d    = !phase_q;
          fill_color = phase_q ? '0 : FAULT_COLOR;
        end else begin
          flt_div_d  = fault_inc;
        end
      end
      ST_SIM: begin
        fill_color = scale_color(cfg_i.sim_color, FIXED_BRIGHT, cfg_i.channel_order);
      end
      default: begin
        fill_color = scale_color(cfg_i.fallback_color, FIXED_BRIGHT, cfg_i.channel_order);
      end
    endcase
    for (int i = 0; i < LED_COUNT; i++) begin
      req_o.colors[i] = is_chase ? chase_frame[i] : fill_color;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q    <= BREATH_RESET;
      phase_q    <= 1'b0;
      plug_cnt_q <= '0;
      flt_div_q  <= '0;
    end else if (fire_i) begin
      level_q    <= level_d;
      phase_q    <= phase_d;
      plug_cnt_q <= plug_cnt_d;
      flt_div_q  <= flt_div_d;
    end
  end

  // chase ring rotates toward entry 0
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CHASE_LENGTH; i++) begin
        ring_q[i] <= chase_init(i);
      end
    end else if (fire_i && is_chase) begin
      for (int i = 0; i < CHASE_LENGTH - 1; i++) begin
        ring_q[i] <= ring_q[i + 1];
      end
      ring_q[CHASE_LENGTH-1] <= ring_q[0];
    end
  end

endmodule

[hdl/slesq_frame_tx.sv]
// ----------------------------------------------------------------------------
// slesq_frame_tx
// Frame buffer that streams one LED color word per transaction.
// ----------------------------------------------------------------------------
module slesq_frame_tx
  import slesq_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   load_i,
  input  frame_t                 colors_i,
  output logic                   load_ready_o,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  output logic                   m_axis_tlast
);

  logic               busy_q, busy_d;
  logic [CNT_W-1:0]   rem_q, rem_d;
  logic [IDX_W-1:0]   pos_q, pos_d;
  logic [COLOR_W-1:0] led_q [LED_COUNT];
  logic               beat;
  logic               last;

  assign last          = (rem_q == CNT_W'(1));
  assign beat          = busy_q && m_axis_tready;
  assign load_ready_o  = !busy_q || (beat && last);
  assign m_axis_tvalid = busy_q;
  assign m_axis_tlast  = last;
  assign m_axis_tdata  = {{OUT_PAD_W{1'b0}}, led_q[0], pos_q};

  always_comb begin
    busy_d = busy_q;
    rem_d  = rem_q;
    pos_d  = pos_q;
    if (load_i) begin
      busy_d = 1'b1;
      rem_d  = FRAME_LEN;
      pos_d  = '0;
    end else if (beat) begin
      busy_d = !last;
      rem_d  = rem_q - CNT_W'(1);
      pos_d  = pos_q + IDX_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      rem_q  <= '0;
      pos_q  <= '0;
    end else begin
      busy_q <= busy_d;
      rem_q  <= rem_d;
      pos_q  <= pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      for (int i = 0; i < LED_COUNT; i++) begin
        led_q[i] <= colors_i[i];
      end
    end else if (beat) begin
      for (int i = 0; i < LED_COUNT - 1; i++) begin
        led_q[i] <= led_q[i + 1];
      end
    end
  end

endmodule

[hdl/status_led_effect_sequencer_unit.sv]
// ----------------------------------------------------------------------------
// status_led_effect_sequencer_unit
// Turns charger state ticks into frames of LED color words.
//
//  channel  | direction | handshake               | payload
//  ---------+-----------+-------------------------+------------------------------
//  s_axis   | in        | s_axis_tvalid/tready    | tdata[3:0] charger_state
//  m_axis   | out       | m_axis_tvalid/tready    | tdata[2:0] led_index,
//           |           |                         | tdata[26:3] led_rgb,
//           |           |                         | tlast frame_last
//  cfg      | in        | cfg_valid_i/cfg_ready_o | cfg_addr_i index, cfg_data_i
//
// a tick waits in the input register until it is taken, then the effect logic builds
// the whole frame in one pass and loads it into the frame buffer
// a frame leaves at one LED per cycle while m_axis_tready is high; ticks without
// a frame are taken without waiting for the frame buffer
// the frame buffer reloads in the cycle its last word is taken
// reset restores the register defaults, the breathing and blink state and the chase ring
// ----------------------------------------------------------------------------
module status_led_effect_sequencer_unit
  import slesq_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // [3:0] charger_state, [7:4] zero
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // [2:0] led_index, [26:3] led_rgb
  output logic                   m_axis_tlast,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CFG_ADDR_W-1:0]  cfg_addr_i,
  input  logic [COLOR_W-1:0]     cfg_data_i
);

  logic               in_valid_q, in_valid_d;
  logic [STATE_W-1:0] in_state_q;
  logic               in_accept;
  logic               consume;
  logic               load_ready;
  cfg_t               cfg;
  frame_req_t         req;

  assign consume       = in_valid_q && (load_ready || !req.emit);
  assign s_axis_tready = !in_valid_q || consume;
  assign in_accept     = s_axis_tvalid && s_axis_tready;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_accept) begin
      in_valid_d = 1'b1;
    end else if (consume) begin
      in_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_state_q <= s_axis_tdata[STATE_W-1:0];
    end
  end

  slesq_cfg_regs u_cfg_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_o       (cfg)
  );

  slesq_effect_core u_effect_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .fire_i  (consume),
    .state_i (in_state_q),
    .cfg_i   (cfg),
    .req_o   (req)
  );

  slesq_frame_tx u_frame_tx (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (consume && req.emit),
    .colors_i      (req.colors),
    .load_ready_o  (load_ready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

[hdl/slesq_checker.sv]
// ----------------------------------------------------------------------------
// slesq_checker
// Port-level checks of frame structure on the LED output stream.
// ----------------------------------------------------------------------------
module slesq_checker
  import slesq_pkg::*;
(
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   m_axis_tvalid,
  input logic                   m_axis_tready,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata,
  input logic                   m_axis_tlast
);

  logic [CNT_W-1:0] beat_q;
  logic             out_beat;

  assign out_beat = m_axis_tvalid && m_axis_tready;

  // position of the next output transaction within its frame
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      beat_q <= '0;
    end else if (out_beat) begin
      beat_q <= m_axis_tlast ? '0 : beat_q + CNT_W'(1);
    end
  end

  a_last_at_frame_end : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tlast == (beat_q == LAST_BEAT)))
    else $error("tlast not on the last LED of the frame");

  a_index_follows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[IDX_W-1:0] == IDX_W'(beat_q)))
    else $error("led_index out of sequence");

  a_pad_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[OUT_TDATA_W-1:IDX_W+COLOR_W] == '0))
    else $error("tdata padding not zero");

  a_stall_holds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output transaction changed while stalled");

endmodule

bind status_led_effect_sequencer_unit slesq_checker u_slesq_checker (.*);

[tb/sv/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the status LED effect sequencer. Charger state ticks
// are pushed into the slave stream. A scoreboard keeps its own copy of the
// breathing, blink and chase state and of the color registers. It predicts
// every LED word and compares it with the master stream in order. Both stream
// sides stall at random, and the receiver holds off once for a long stretch.
// ----------------------------------------------------------------------------
module tb_top;
  import slesq_pkg::*;

  localparam int QUIET_LIMIT      = 2000;
  localparam int SETTLE_CYCLES    = 16;
  localparam int LONG_HOLD_CYCLES = 200;

  class led_frame_scoreboard;
    typedef struct {
      logic [IDX_W-1:0]   idx;
      logic [COLOR_W-1:0] rgb;
      logic               last;
    } led_word_t;

    localparam logic [COLOR_W-1:0] PLUG_BLINK_RGB  = 24'h000050;
    localparam logic [COLOR_W-1:0] FAULT_BLINK_RGB = 24'h9F0000;
    localparam logic [COLOR_W-1:0] RAMP_TOP_RGB    = 24'h0000AF;
    localparam int                 FULL_LUM        = 100;
    localparam int                 PLUG_TICKS      = 25;
    localparam int                 FAULT_TICKS     = 15;

    logic [COLOR_W-1:0] idle_rgb;
    logic [COLOR_W-1:0] done_rgb;
    logic [COLOR_W-1:0] sim_rgb;
    logic [COLOR_W-1:0] fallback_rgb;
    channel_order_e     byte_order;

    logic [4:0]         breath_lvl;
    logic               phase_flag;
    logic [4:0]         plug_cnt;
    logic [3:0]         flt_ticks;
    logic [COLOR_W-1:0] ring [CHASE_LENGTH];

    led_word_t pending_leds[$];
    int        errors;

    function new();
      idle_rgb     = 24'h000080;
      done_rgb     = 24'h008000;
      sim_rgb      = 24'hFFC0CB;
      fallback_rgb = 24'h800000;
      byte_order   = ORD_RGB;
      breath_lvl   = 5'd10;
      phase_flag   = 1'b0;
      plug_cnt     = '0;
      flt_ticks    = '0;
      for (int i = 0; i < CHASE_LENGTH; i++) begin
        ring[i] = (i < 18) ? RAMP_TOP_RGB - 24'(10 * i) : '0;
      end
      errors = 0;
    endfunction

    function void set_reg(cfg_reg_e r, logic [COLOR_W-1:0] v);
      case (r)
        REG_IDLE_COLOR:     idle_rgb = v;
        REG_DONE_COLOR:     done_rgb = v;
        REG_SIM_COLOR:      sim_rgb = v;
        REG_FALLBACK_COLOR: fallback_rgb = v;
        REG_CHANNEL_ORDER:  byte_order = channel_order_e'(v[1:0]);
        default: ;
      endcase
    endfunction

    // per-byte c*lum/255, then reorder
    function logic [COLOR_W-1:0] shade(logic [COLOR_W-1:0] rgb, int lum);
      logic [7:0] r;
      logic [7:0] g;
      logic [7:0] b;
      r = 8'(int'(rgb[23:16]) * lum / 255);
      g = 8'(int'(rgb[15:8]) * lum / 255);
      b = 8'(int'(rgb[7:0]) * lum / 255);
      case (byte_order)
        ORD_BGR: return {b, g, r};
        ORD_GRB: return {g, r, b};
        ORD_RBG: return {r, b, g};
        default: return {r, g, b};
      endcase
    endfunction

    // 5-bit level, wraps if a blink flipped the direction past a turning point
    function void breathe();
      if (!phase_flag) begin
        breath_lvl = breath_lvl + 5'd1;
        if (breath_lvl == 5'd30) phase_flag = 1'b1;
      end else begin
        breath_lvl = breath_lvl - 5'd1;
        if (breath_lvl == 5'd5) phase_flag = 1'b0;
      end
    endfunction

    function void push_led(int i, logic [COLOR_W-1:0] rgb);
      led_word_t w;
      w.idx  = IDX_W'(i);
      w.rgb  = rgb;
      w.last = (i == LED_COUNT - 1);
      pending_leds.push_back(w);
    endfunction

    function void fill_frame(logic [COLOR_W-1:0] rgb);
      for (int i = 0; i < LED_COUNT; i++) push_led(i, rgb);
    endfunction

    function void note_tick(logic [STATE_W-1:0] st);
      logic [COLOR_W-1:0] head;
      case (st)
        ST_REBOOT: fill_frame(shade(idle_rgb, FULL_LUM));
        ST_IDLE: begin
          breathe();
          fill_frame(shade(idle_rgb, 10 + 5 * int'(breath_lvl)));
        end
        ST_PLUGGED: begin
          plug_cnt = plug_cnt + 5'd1;
          if (int'(plug_cnt) >= PLUG_TICKS) begin
            plug_cnt   = '0;
            phase_flag = ~phase_flag;
            fill_frame(phase_flag ? '0 : PLUG_BLINK_RGB);
          end
        end
        ST_CHARGING: begin
          head = ring[0];
          for (int i = 0; i < CHASE_LENGTH - 1; i++) ring[i] = ring[i + 1];
          ring[CHASE_LENGTH - 1] = head;
          for (int i = 0; i < LED_COUNT; i++) begin
            push_led(i, (i < CHASE_LENGTH) ? ring[i] : '0);
          end
        end
        ST_DONE: fill_frame(shade(done_rgb, FULL_LUM));
        ST_STOP: begin
          breathe();
          fill_frame(shade(done_rgb, 10 + 5 * int'(breath_lvl)));
        end
        ST_FAULT: begin
          flt_ticks = flt_ticks + 4'd1;
          if (int'(flt_ticks) >= FAULT_TICKS) begin
            flt_ticks  = '0;
            phase_flag = ~phase_flag;
            fill_frame(phase_flag ? FAULT_BLINK_RGB : '0);
          end
        end
        ST_SIM: fill_frame(shade(sim_rgb, FULL_LUM));
        default: fill_frame(shade(fallback_rgb, FULL_LUM));
      endcase
    endfunction

    task report_mismatch(string msg);
      $display("mismatch at %0t: %s", $time, msg);
      errors++;
    endtask

    task check_led(logic [IDX_W-1:0] idx, logic [COLOR_W-1:0] rgb, logic last,
                   logic [OUT_PAD_W-1:0] pad);
      led_word_t w;
      if (pending_leds.size() == 0) begin
        report_mismatch($sformatf("unexpected led %0d color %06h", idx, rgb));
        return;
      end
      w = pending_leds.pop_front();
      if (idx !== w.idx)
        report_mismatch($sformatf("led index %0d, want %0d", idx, w.idx));
      if (rgb !== w.rgb)
        report_mismatch($sformatf("led %0d color %06h, want %06h", w.idx, rgb, w.rgb));
      if (last !== w.last)
        report_mismatch($sformatf("led %0d tlast %b, want %b", w.idx, last, w.last));
      if (pad !== '0)
        report_mismatch($sformatf("led %0d tdata padding %h", w.idx, pad));
    endtask
  endclass

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   m_axis_tlast;
  logic                   cfg_valid_i = 1'b0;
  logic                   cfg_ready_o;
  logic [CFG_ADDR_W-1:0]  cfg_addr_i = '0;
  logic [COLOR_W-1:0]     cfg_data_i = '0;

  led_frame_scoreboard sb;
  int  ticks_sent = 0;
  int  ticks_noted = 0;
  int  quiet_cycles = 0;
  bit  gaps_on = 1'b1;
  bit  long_hold = 1'b0;

  status_led_effect_sequencer_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // every transaction is seen here, on values from before the edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) sb.set_reg(cfg_reg_e'(cfg_addr_i), cfg_data_i);
      if (s_axis_tvalid && s_axis_tready) begin
        sb.note_tick(s_axis_tdata[STATE_W-1:0]);
        ticks_noted++;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        sb.check_led(m_axis_tdata[IDX_W-1:0], m_axis_tdata[IDX_W +: COLOR_W],
                     m_axis_tlast, m_axis_tdata[OUT_TDATA_W-1 -: OUT_PAD_W]);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // receiver: random stall bursts, plus one long hold when asked
  initial begin
    forever begin
      @(posedge clk_i);
      if (long_hold) begin
        m_axis_tready <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(posedge clk_i);
        long_hold = 1'b0;
      end else if (gaps_on && $urandom_range(0, 4) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
    end
  end

  task automatic send_tick(input logic [STATE_W-1:0] st);
    s_axis_tdata  <= {{(IN_TDATA_W - STATE_W){1'b0}}, st};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (s_axis_tready !== 1'b1);
    ticks_sent++;
    // let the scoreboard take this tick before anyone reads its state
    wait (ticks_noted == ticks_sent);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
  endtask

  task automatic write_reg(input cfg_reg_e r, input logic [COLOR_W-1:0] v);
    cfg_addr_i  <= r;
    cfg_data_i  <= v;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
  endtask

  task automatic write_all(input logic [COLOR_W-1:0] idle_c, input logic [COLOR_W-1:0] done_c,
                           input logic [COLOR_W-1:0] sim_c, input logic [COLOR_W-1:0] fb_c,
                           input channel_order_e ord);
    write_reg(REG_IDLE_COLOR, idle_c);
    write_reg(REG_DONE_COLOR, done_c);
    write_reg(REG_SIM_COLOR, sim_c);
    write_reg(REG_FALLBACK_COLOR, fb_c);
    write_reg(REG_CHANNEL_ORDER, COLOR_W'(ord));
    cfg_valid_i <= 1'b0;
  endtask

  task automatic write_random(input channel_order_e ord);
    write_all(COLOR_W'($urandom), COLOR_W'($urandom), COLOR_W'($urandom),
              COLOR_W'($urandom), ord);
  endtask

  // blink ticks leave no frame, so give the pipeline time before reconfiguring
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (sb.pending_leds.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic send_run();
    int len;
    case ($urandom_range(0, 5))
      0: begin
        len = $urandom_range(20, 30);
        repeat (len) send_tick(ST_PLUGGED);
      end
      1: begin
        len = $urandom_range(10, 20);
        repeat (len) send_tick(ST_FAULT);
      end
      2: begin
        len = $urandom_range(5, 30);
        repeat (len) send_tick($urandom_range(0, 1) ? ST_IDLE : ST_STOP);
      end
      3: begin
        len = $urandom_range(4, 30);
        repeat (len) send_tick(ST_CHARGING);
      end
      4: begin
        len = $urandom_range(3, 8);
        repeat (len) begin
          case ($urandom_range(0, 3))
            0: send_tick(ST_REBOOT);
            1: send_tick(ST_DONE);
            2: send_tick(ST_SIM);
            default: send_tick(STATE_W'($urandom_range(8, 15)));
          endcase
        end
      end
      default: begin
        len = $urandom_range(1, 4);
        repeat (len) send_tick(STATE_W'($urandom_range(0, 15)));
      end
    endcase
  endtask

  task automatic random_ticks(input int n);
    int start;
    start = ticks_sent;
    while (ticks_sent - start < n) send_run();
  endtask

  // push the breathing level past both turning points with a blink toggle
  task automatic breath_wrap();
    int guard;
    guard = 0;
    while (!(sb.phase_flag && sb.breath_lvl == 5'd30) && guard < 80) begin
      send_tick(ST_IDLE);
      guard++;
    end
    guard = 0;
    while (sb.phase_flag && guard < 32) begin
      send_tick(ST_PLUGGED);
      guard++;
    end
    repeat (4) send_tick(ST_IDLE);
    guard = 0;
    while (!(!sb.phase_flag && sb.breath_lvl == 5'd5) && guard < 80) begin
      send_tick(ST_STOP);
      guard++;
    end
    guard = 0;
    while (!sb.phase_flag && guard < 20) begin
      send_tick(ST_FAULT);
      guard++;
    end
    repeat (7) send_tick(ST_STOP);
  endtask

  initial begin
    sb = new();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // every state once on the reset registers, then a few chase and breath steps
    for (int s = 0; s < 16; s++) send_tick(STATE_W'(s));
    send_tick(ST_CHARGING);
    send_tick(ST_CHARGING);
    send_tick(ST_IDLE);
    send_tick(ST_STOP);
    settle();

    write_all('0, '0, '0, '0, ORD_RGB);
    long_hold = 1'b1;
    random_ticks(20);
    settle();

    write_all('1, '1, '1, '1, ORD_RBG);
    random_ticks(25);
    settle();

    write_random(ORD_BGR);
    breath_wrap();
    settle();

    write_random(ORD_GRB);
    random_ticks(25);
    settle();

    write_random(channel_order_e'($urandom_range(0, 3)));
    random_ticks(25);
    settle();

    gaps_on = 1'b0;
    write_random(channel_order_e'($urandom_range(0, 3)));
    random_ticks(20);
    settle();

    if (sb.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
